/* hdl/pcp_pkg.sv */
// pcp_pkg: shared types and constants for the port classified token bucket policer.
// Holds classification codes, register indexes, the descriptor and result words
// and the configuration bundle. No dependencies.
package pcp_pkg;

	localparam int TIME_BITS_DEF  = 48;
	localparam int TOKEN_BITS_DEF = 32;
	localparam int NUM_CLASSES    = 3;
	localparam int RATE_BITS      = 16;
	localparam int SIZE_BITS      = 32;
	localparam int LEN_BITS       = 16;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 3;
	localparam int QUEUE_DEPTH    = 4;
	localparam int OUT_DEPTH      = 4;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [15:0] PORT_WEB       = 16'd80;
	localparam logic [15:0] PORT_SECURE    = 16'd443;

	typedef logic [1:0] class_t;
	localparam class_t CLASS_DEFAULT = 2'd0;
	localparam class_t CLASS_WEB     = 2'd1;
	localparam class_t CLASS_SECURE  = 2'd2;

	typedef logic [CFG_INDEX_BITS-1:0] reg_index_t;
	localparam reg_index_t REG_ENABLE_MASK  = 3'd0;
	localparam reg_index_t REG_RATE_DEFAULT = 3'd1;
	localparam reg_index_t REG_SIZE_DEFAULT = 3'd2;
	localparam reg_index_t REG_RATE_WEB     = 3'd3;
	localparam reg_index_t REG_SIZE_WEB     = 3'd4;
	localparam reg_index_t REG_RATE_SECURE  = 3'd5;
	localparam reg_index_t REG_SIZE_SECURE  = 3'd6;

	// classified descriptor handed from front to back
	typedef struct packed {
		logic                policed;
		class_t              flow_class;
		logic [LEN_BITS-1:0] length;
	} desc_t;

	// one result word
	typedef struct packed {
		logic   drop;
		class_t flow_class;
		logic   policed;
	} res_t;

	// per-class bucket settings
	typedef struct packed {
		logic [NUM_CLASSES-1:0][RATE_BITS-1:0] rate;
		logic [NUM_CLASSES-1:0][SIZE_BITS-1:0] size;
	} cfg_t;

endpackage

/* hdl/pcp_fifo.sv */
// pcp_fifo: small register based queue with full/empty flags and a fill count.
// Used between front and back and as the result queue. No dependencies.
module pcp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [WIDTH-1:0]             wr_data,
	output logic                         full,
	input  logic                         rd_en,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/pcp_front.sv */
// pcp_front: classifies accepted descriptors and measures elapsed time per class.
// Owns the per-class last refill timestamps. Depends on pcp_pkg.
module pcp_front import pcp_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [15:0]              ether_type,
	input  logic [7:0]               ip_protocol,
	input  logic [15:0]              dest_port,
	input  logic [LEN_BITS-1:0]      packet_length,
	input  logic [TIME_BITS-1:0]     now_us,
	input  logic [NUM_CLASSES-1:0]   enable_mask,
	output desc_t                    desc,
	output logic [TIME_BITS-1:0]     elapsed
);

	logic [TIME_BITS-1:0] last_q [NUM_CLASSES];
	logic                 is_tcp;
	class_t               cls;
	logic                 en;
	logic [TIME_BITS-1:0] last_sel;

	always_comb begin
		is_tcp = (ether_type == ETHERTYPE_IPV4) && (ip_protocol == PROTO_TCP);
		if (!is_tcp) begin
			cls = CLASS_DEFAULT;
		end else if (dest_port == PORT_WEB) begin
			cls = CLASS_WEB;
		end else if (dest_port == PORT_SECURE) begin
			cls = CLASS_SECURE;
		end else begin
			cls = CLASS_DEFAULT;
		end
		unique case (cls)
			CLASS_WEB: begin
				en       = enable_mask[1];
				last_sel = last_q[1];
			end
			CLASS_SECURE: begin
				en       = enable_mask[2];
				last_sel = last_q[2];
			end
			default: begin
				en       = enable_mask[0];
				last_sel = last_q[0];
			end
		endcase
		desc.policed    = is_tcp && en;
		desc.flow_class = cls;
		desc.length     = packet_length;
		elapsed         = now_us - last_sel;
	end

	// record the refill time at acceptance; the back applies refills in the same order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				last_q[i] <= '0;
			end
		end else if (accept && desc.policed) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				if (cls == class_t'(i)) begin
					last_q[i] <= now_us;
				end
			end
		end
	end

endmodule

/* hdl/pcp_back.sv */
// pcp_back: refills and charges the class buckets, one descriptor per cycle while
// the result queue has room. Stage s1 holds the refill product; the bucket update
// writes the result queue. Depends on pcp_pkg.
module pcp_back import pcp_pkg::*; #(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int TOKEN_BITS = TOKEN_BITS_DEF,
	parameter int OUT_DEPTH_P = OUT_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfg_t                             cfg,
	input  logic                             q_empty,
	input  desc_t                            q_desc,
	input  logic [TIME_BITS-1:0]             q_elapsed,
	output logic                             q_rd,
	input  logic [$clog2(OUT_DEPTH_P+1)-1:0] out_count,
	output logic                             out_wr,
	output res_t                             out_res
);

	localparam int PW  = TIME_BITS + RATE_BITS;
	localparam int EW  = (PW > 64) ? PW : 64;
	localparam int CW  = (TOKEN_BITS > 64) ? TOKEN_BITS + 1 : 65;
	localparam int NW  = $clog2(OUT_DEPTH_P+1) + 1;

	logic                  valid_s1;
	desc_t                 desc_s1;
	logic [PW-1:0]         prod_s1;
	logic [TOKEN_BITS-1:0] token_q [NUM_CLASSES];

	logic [RATE_BITS-1:0]  rate_sel;
	logic [SIZE_BITS-1:0]  size_sel;
	logic [TOKEN_BITS-1:0] tok;
	logic [TOKEN_BITS-1:0] cap;
	logic [EW-1:0]         prod_ext;
	logic                  ovf;
	logic [CW-1:0]         add_w;
	logic [CW-1:0]         room_w;
	logic [CW-1:0]         sum_w;
	logic [TOKEN_BITS-1:0] refilled;
	logic [TOKEN_BITS-1:0] len_w;
	logic                  drop_c;
	logic [TOKEN_BITS-1:0] tok_next;

	// take a descriptor only when the result queue has room for everything in flight
	assign q_rd = !q_empty && ((NW'(out_count) + NW'(valid_s1)) < NW'(OUT_DEPTH_P));

	always_comb begin
		unique case (q_desc.flow_class)
			CLASS_WEB:    rate_sel = cfg.rate[1];
			CLASS_SECURE: rate_sel = cfg.rate[2];
			default:      rate_sel = cfg.rate[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= q_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			desc_s1 <= q_desc;
			prod_s1 <= PW'(q_elapsed) * PW'(rate_sel);
		end
	end

	always_comb begin
		unique case (desc_s1.flow_class)
			CLASS_WEB: begin
				tok      = token_q[1];
				size_sel = cfg.size[1];
			end
			CLASS_SECURE: begin
				tok      = token_q[2];
				size_sel = cfg.size[2];
			end
			default: begin
				tok      = token_q[0];
				size_sel = cfg.size[0];
			end
		endcase
		cap      = TOKEN_BITS'(size_sel);
		prod_ext = EW'(prod_s1);
		// refill beyond 64 bits saturates the bucket
		ovf      = (prod_ext >> 64) != '0;
		add_w    = CW'(prod_ext[63:0]);
		room_w   = CW'(cap - tok);
		sum_w    = CW'(tok) + add_w;
		if (ovf || (tok >= cap) || (add_w >= room_w)) begin
			refilled = cap;
		end else begin
			refilled = sum_w[TOKEN_BITS-1:0];
		end
		len_w    = TOKEN_BITS'(desc_s1.length);
		drop_c   = len_w > refilled;
		tok_next = drop_c ? refilled : refilled - len_w;

		out_wr             = valid_s1;
		out_res.policed    = desc_s1.policed;
		out_res.flow_class = desc_s1.flow_class;
		out_res.drop       = desc_s1.policed && drop_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				token_q[i] <= '0;
			end
		end else if (valid_s1 && desc_s1.policed) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				if (desc_s1.flow_class == class_t'(i)) begin
					token_q[i] <= tok_next;
				end
			end
		end
	end

endmodule

/* hdl/port_classified_token_bucket_policer.sv */
// port_classified_token_bucket_policer: top level; config registers, front, queues, back.
// Throughput: one word per cycle sustained while the result queue has room. A result
// passes the front queue, refill product stage s1 and the result queue in that order.
// Reset: arst_n clears config registers, buckets, refill times and both queues at once.
// Depends on pcp_pkg, pcp_fifo, pcp_front and pcp_back.
module port_classified_token_bucket_policer import pcp_pkg::*; #(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// input queue side
	input  logic                      push,
	output logic                      full,
	input  logic [15:0]               ether_type,
	input  logic [7:0]                ip_protocol,
	input  logic [15:0]               dest_port,
	input  logic [LEN_BITS-1:0]       packet_length,
	input  logic [TIME_BITS-1:0]      now_us,
	// result queue side
	output logic                      empty,
	input  logic                      pop,
	output logic                      drop,
	output class_t                    flow_class,
	output logic                      policed
);

	localparam int QW = $bits(desc_t) + TIME_BITS;

	logic [NUM_CLASSES-1:0] enable_mask_q;
	cfg_t                   cfg_q;

	logic                   accept;
	desc_t                  f_desc;
	logic [TIME_BITS-1:0]   f_elapsed;
	logic [QW-1:0]          q_rd_data;
	logic                   q_empty;
	logic                   q_rd;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	logic                   out_wr;
	res_t                   out_res;
	logic [$bits(res_t)-1:0] out_data;
	logic                   out_full;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
	res_t                   res;

	// Config registers, read by front and back unstaged; unknown indexes are dropped. The
	// user must write them only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= '0;
			cfg_q         <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE_MASK:  enable_mask_q  <= cfg_data[NUM_CLASSES-1:0];
				REG_RATE_DEFAULT: cfg_q.rate[0]  <= cfg_data[RATE_BITS-1:0];
				REG_SIZE_DEFAULT: cfg_q.size[0]  <= cfg_data[SIZE_BITS-1:0];
				REG_RATE_WEB:     cfg_q.rate[1]  <= cfg_data[RATE_BITS-1:0];
				REG_SIZE_WEB:     cfg_q.size[1]  <= cfg_data[SIZE_BITS-1:0];
				REG_RATE_SECURE:  cfg_q.rate[2]  <= cfg_data[RATE_BITS-1:0];
				REG_SIZE_SECURE:  cfg_q.size[2]  <= cfg_data[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// A word enters whenever the front queue has a free slot; the front classifies
	// it and, for a policed word, stamps the class refill time in the same cycle.
	assign accept = push && !full;

	pcp_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.ether_type    (ether_type),
		.ip_protocol   (ip_protocol),
		.dest_port     (dest_port),
		.packet_length (packet_length),
		.now_us        (now_us),
		.enable_mask   (enable_mask_q),
		.desc          (f_desc),
		.elapsed       (f_elapsed)
	);

	// Queue between front and back: lets the front keep accepting while the
	// back waits on a full result queue.
	pcp_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data ({f_desc, f_elapsed}),
		.full    (full),
		.rd_en   (q_rd),
		.rd_data (q_rd_data),
		.empty   (q_empty),
		.count   (q_count)
	);

	// Back: multiply elapsed time by rate into s1, then refill, cap and charge the
	// bucket and write the result word. The fill count of the front queue is also
	// folded into the q_empty input of the back.
	pcp_back #(
		.TIME_BITS   (TIME_BITS),
		.TOKEN_BITS  (TOKEN_BITS),
		.OUT_DEPTH_P (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty || (q_count == '0)),
		.q_desc    (desc_t'(q_rd_data[QW-1:TIME_BITS])),
		.q_elapsed (q_rd_data[TIME_BITS-1:0]),
		.q_rd      (q_rd),
		.out_count (out_count),
		.out_wr    (out_wr),
		.out_res   (out_res)
	);

	// Result queue: the back reserves a slot before it takes a word, so a write
	// never meets a full queue.
	pcp_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (out_res),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_data),
		.empty   (empty),
		.count   (out_count)
	);

	// out_full cannot rise while a write is pending. drop is masked only when out_full
	// and empty are both set, which the result queue never shows at once.
	assign res        = res_t'(out_data);
	assign drop       = res.drop && !(out_full && empty);
	assign flow_class = res.flow_class;
	assign policed    = res.policed;

endmodule

/* tb/tb_port_classified_token_bucket_policer.sv */
// tb_port_classified_token_bucket_policer: self-checking bench for the port classified
// token bucket policer; predicts each verdict word and compares it field by field.
// Depends on pcp_pkg and port_classified_token_bucket_policer.
`timescale 1ns / 100ps

module tb_port_classified_token_bucket_policer;
	import pcp_pkg::*;

	localparam int  STALL_LIMIT   = 4000;  // cycles with no word moving on either side
	localparam int  RANDOM_PHASES = 12;
	localparam int  PHASE_PKTS    = 125;
	localparam int  REPORT_MAX    = 10;
	localparam reg_index_t REG_UNUSED = 3'd7;  // decoded by nobody, write must be ignored

	typedef struct packed {
		logic [15:0]              ether_type;
		logic [7:0]               ip_protocol;
		logic [15:0]              dest_port;
		logic [LEN_BITS-1:0]      packet_length;
		logic [TIME_BITS_DEF-1:0] now_us;
	} descriptor_t;

	// clock, reset and all block inputs start at known values
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	reg_index_t                cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      push = 1'b0;
	logic                      full;
	logic [15:0]               ether_type = '0;
	logic [7:0]                ip_protocol = '0;
	logic [15:0]               dest_port = '0;
	logic [LEN_BITS-1:0]       packet_length = '0;
	logic [TIME_BITS_DEF-1:0]  now_us = '0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic                      drop;
	class_t                    flow_class;
	logic                      policed;

	// predictor copy of the registers and the buckets
	logic [2:0]                bucket_enable;
	logic [RATE_BITS-1:0]      bucket_rate [NUM_CLASSES];
	logic [SIZE_BITS-1:0]      bucket_size [NUM_CLASSES];
	logic [TOKEN_BITS_DEF-1:0] bucket_tokens [NUM_CLASSES];
	logic [TIME_BITS_DEF-1:0]  bucket_stamp [NUM_CLASSES];

	descriptor_t               pending_pkts [$];
	res_t                      expected_verdicts [$];
	descriptor_t               cur_pkt;
	logic [TIME_BITS_DEF-1:0]  sim_clock_us = '0;
	int                        send_idle_pct = 0;
	int                        recv_idle_pct = 0;
	int                        mismatches = 0;
	int                        stall_cycles = 0;

	port_classified_token_bucket_policer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.ether_type    (ether_type),
		.ip_protocol   (ip_protocol),
		.dest_port     (dest_port),
		.packet_length (packet_length),
		.now_us        (now_us),
		.empty         (empty),
		.pop           (pop),
		.drop          (drop),
		.flow_class    (flow_class),
		.policed       (policed)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Classify one descriptor, refill and charge its bucket, and return the verdict word.
	function automatic res_t police_packet(input descriptor_t pkt);
		res_t                     verdict;
		class_t                   cls;
		logic [TIME_BITS_DEF-1:0] elapsed;
		logic [63:0]              gain;
		logic [63:0]              tokens;
		logic [63:0]              cap;
		verdict = '0;
		// anything but IPv4 TCP goes through untouched
		if (pkt.ether_type != ETHERTYPE_IPV4 || pkt.ip_protocol != PROTO_TCP)
			return verdict;
		if (pkt.dest_port == PORT_WEB)
			cls = CLASS_WEB;
		else if (pkt.dest_port == PORT_SECURE)
			cls = CLASS_SECURE;
		else
			cls = CLASS_DEFAULT;
		verdict.flow_class = cls;
		// class without a bucket: report the class, leave the state alone
		if (!bucket_enable[cls])
			return verdict;
		verdict.policed = 1'b1;
		// elapsed time wraps, so a timestamp that goes back reads as a long interval
		elapsed = pkt.now_us - bucket_stamp[cls];
		gain    = {16'b0, elapsed} * {48'b0, bucket_rate[cls]};
		tokens  = {32'b0, bucket_tokens[cls]};
		cap     = {32'b0, bucket_size[cls]};
		// saturate at capacity; this also cuts an over-full bucket after size shrinks
		if (tokens >= cap || gain >= cap - tokens)
			tokens = cap;
		else
			tokens = tokens + gain;
		bucket_stamp[cls] = pkt.now_us;
		// a dropped packet still records the refill
		if ({48'b0, pkt.packet_length} > tokens)
			verdict.drop = 1'b1;
		else
			tokens = tokens - {48'b0, pkt.packet_length};
		bucket_tokens[cls] = tokens[TOKEN_BITS_DEF-1:0];
		return verdict;
	endfunction

	function automatic descriptor_t descriptor(input logic [15:0] et, input logic [7:0] proto,
			input logic [15:0] port, input logic [15:0] len, input logic [47:0] stamp);
		descriptor_t pkt;
		pkt.ether_type    = et;
		pkt.ip_protocol   = proto;
		pkt.dest_port     = port;
		pkt.packet_length = len;
		pkt.now_us        = stamp;
		return pkt;
	endfunction

	function automatic descriptor_t tcp(input logic [15:0] port, input logic [15:0] len,
			input logic [47:0] stamp);
		return descriptor(ETHERTYPE_IPV4, PROTO_TCP, port, len, stamp);
	endfunction

	function automatic logic [RATE_BITS-1:0] pick_rate();
		int r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		if (r < 80) return RATE_BITS'($urandom_range(1, 300));
		return RATE_BITS'($urandom());
	endfunction

	function automatic logic [SIZE_BITS-1:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		if (r < 80) return SIZE_BITS'($urandom_range(100, 20000));
		return SIZE_BITS'($urandom());
	endfunction

	// Build one random descriptor: mostly IPv4 TCP on a slowly moving clock,
	// with noise frames, big jumps, backward steps and full-range fields mixed in.
	function automatic descriptor_t gen_packet();
		descriptor_t pkt;
		logic [63:0] wide;
		int          r;
		r = $urandom_range(99);
		if (r < 70)
			sim_clock_us = sim_clock_us + TIME_BITS_DEF'($urandom_range(0, 20));
		else if (r < 85)
			sim_clock_us = sim_clock_us + TIME_BITS_DEF'($urandom_range(0, 2000));
		else if (r < 92) begin
			wide = {$urandom(), $urandom()};
			sim_clock_us = wide[TIME_BITS_DEF-1:0];
		end else if (r < 96)
			sim_clock_us = sim_clock_us - TIME_BITS_DEF'($urandom_range(1, 100));
		pkt.now_us = sim_clock_us;

		r = $urandom_range(99);
		if (r < 10) pkt.packet_length = '0;
		else if (r < 15) pkt.packet_length = '1;
		else if (r < 40) pkt.packet_length = LEN_BITS'($urandom());
		else pkt.packet_length = LEN_BITS'($urandom_range(0, 1500));

		r = $urandom_range(99);
		if (r < 80) begin
			pkt.ether_type  = ETHERTYPE_IPV4;
			pkt.ip_protocol = PROTO_TCP;
			case ($urandom_range(2))
				0: pkt.dest_port = PORT_WEB;
				1: pkt.dest_port = PORT_SECURE;
				default: pkt.dest_port = 16'($urandom());
			endcase
		end else begin
			pkt.ether_type  = 16'($urandom());
			pkt.ip_protocol = 8'($urandom());
			pkt.dest_port   = 16'($urandom());
			// near misses: right ether type with wrong protocol, or the reverse
			if (r < 87) begin
				pkt.ether_type = ETHERTYPE_IPV4;
				if (pkt.ip_protocol == PROTO_TCP) pkt.ip_protocol = 8'd17;
			end else if (r < 94)
				pkt.ip_protocol = PROTO_TCP;
		end
		return pkt;
	endfunction

	task automatic note_mismatch(input string msg);
		if (mismatches < REPORT_MAX)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Hold until nothing is queued, offered or outstanding; sample at negedge so
	// every nonblocking update of the edge has landed.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_pkts.size() != 0 || push || expected_verdicts.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_ENABLE_MASK:  bucket_enable = data[2:0];
			REG_RATE_DEFAULT: bucket_rate[CLASS_DEFAULT] = data[RATE_BITS-1:0];
			REG_SIZE_DEFAULT: bucket_size[CLASS_DEFAULT] = data;
			REG_RATE_WEB:     bucket_rate[CLASS_WEB] = data[RATE_BITS-1:0];
			REG_SIZE_WEB:     bucket_size[CLASS_WEB] = data;
			REG_RATE_SECURE:  bucket_rate[CLASS_SECURE] = data[RATE_BITS-1:0];
			REG_SIZE_SECURE:  bucket_size[CLASS_SECURE] = data;
			default: ;
		endcase
	endtask

	// Drain the block, then rewrite every register. Unused upper bits carry junk
	// that the block has to mask off.
	task automatic load_settings(input logic [2:0] en,
			input logic [RATE_BITS-1:0] rd, input logic [SIZE_BITS-1:0] sd,
			input logic [RATE_BITS-1:0] rw, input logic [SIZE_BITS-1:0] sw,
			input logic [RATE_BITS-1:0] rs, input logic [SIZE_BITS-1:0] ss);
		logic [31:0] junk;
		wait_drained();
		junk = $urandom();
		write_reg(REG_ENABLE_MASK, {junk[31:3], en});
		write_reg(REG_RATE_DEFAULT, {junk[31:16], rd});
		write_reg(REG_SIZE_DEFAULT, sd);
		write_reg(REG_RATE_WEB, {junk[15:0], rw});
		write_reg(REG_SIZE_WEB, sw);
		write_reg(REG_RATE_SECURE, {~junk[31:16], rs});
		write_reg(REG_SIZE_SECURE, ss);
		write_reg(REG_UNUSED, $urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: offer the next queued descriptor, hold it while full, idle at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				expected_verdicts.push_back(police_packet(cur_pkt));
			if (push && full) begin
				// hold the word on the ports until it is taken
			end else if (pending_pkts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_pkt        = pending_pkts.pop_front();
				push          <= 1'b1;
				ether_type    <= cur_pkt.ether_type;
				ip_protocol   <= cur_pkt.ip_protocol;
				dest_port     <= cur_pkt.dest_port;
				packet_length <= cur_pkt.packet_length;
				now_us        <= cur_pkt.now_us;
			end else
				push <= 1'b0;
		end
	end

	// Monitor: take verdict words at random and check them against the oldest prediction.
	always @(posedge clk) begin : verdict_monitor
		res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_verdicts.size() == 0)
					note_mismatch($sformatf("unexpected word drop=%0b class=%0d policed=%0b",
						drop, flow_class, policed));
				else begin
					want = expected_verdicts.pop_front();
					if (drop !== want.drop || flow_class !== want.flow_class ||
							policed !== want.policed)
						note_mismatch($sformatf(
							"drop exp %0b got %0b, class exp %0d got %0d, policed exp %0b got %0b",
							want.drop, drop, want.flow_class, flow_class,
							want.policed, policed));
				end
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: end the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("[port_classified_token_bucket_policer] ERROR");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		bucket_enable = '0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			bucket_rate[i]   = '0;
			bucket_size[i]   = '0;
			bucket_tokens[i] = '0;
			bucket_stamp[i]  = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: sender idles 23 percent, receiver 83 percent
		send_idle_pct = 23;
		recv_idle_pct = 83;
		load_settings(3'b111, 16'd1, 32'd1000, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 32'd500);
		pending_pkts.push_back(descriptor(16'h86DD, PROTO_TCP, PORT_WEB, 16'd100, '0));
		pending_pkts.push_back(descriptor(ETHERTYPE_IPV4, 8'd17, PORT_SECURE, 16'd100, '0));
		pending_pkts.push_back(descriptor(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, '1));
		pending_pkts.push_back(descriptor('0, '0, '0, '0, '0));
		pending_pkts.push_back(tcp(16'd1234, 16'd0, 48'd0));     // empty bucket, zero length
		pending_pkts.push_back(tcp(16'd0, 16'd1, 48'd0));        // empty bucket: drop
		pending_pkts.push_back(tcp(16'hFFFF, 16'd400, 48'd500)); // partial refill
		pending_pkts.push_back(tcp(16'd79, 16'd1000, 48'd5000)); // refill caps at size
		pending_pkts.push_back(tcp(PORT_WEB, 16'hFFFF, 48'd1));  // max rate, max length
		pending_pkts.push_back(tcp(PORT_WEB, 16'hFFFF, '1));     // huge interval saturates
		pending_pkts.push_back(tcp(PORT_SECURE, 16'd0, 48'd10)); // zero rate
		pending_pkts.push_back(tcp(PORT_SECURE, 16'd1, 48'd20));
		pending_pkts.push_back(tcp(16'd81, 16'd1, 48'd4000));    // time steps backward
		pending_pkts.push_back(tcp(16'd442, 16'd998, 48'd4000)); // same time, no refill
		pending_pkts.push_back(tcp(16'd444, 16'd2, 48'd4000));   // one token short
		pending_pkts.push_back(tcp(16'd1, 16'd0, 48'd6000));     // fill class 0 to 1000

		// shrink class 0 below its holding and turn class 1 off
		load_settings(3'b101, 16'd1, 32'd10, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 32'd500);
		pending_pkts.push_back(tcp(PORT_WEB, 16'd5, 48'd6000));  // class off: unpoliced
		pending_pkts.push_back(tcp(16'd0, 16'd10, 48'd6000));    // over-full bucket cut to 10
		pending_pkts.push_back(tcp(16'd0, 16'd1, 48'd6000));
		pending_pkts.push_back(tcp(PORT_SECURE, 16'd0, 48'd6000));
		sim_clock_us = 48'd6000;

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: load_settings(3'b111, '1, '1, '1, '1, '1, '1);
				1: load_settings(3'b111, '0, '0, '0, '0, '0, '0);
				2: load_settings(3'b000, pick_rate(), pick_size(), pick_rate(), pick_size(),
					pick_rate(), pick_size());
				default: load_settings(($urandom_range(1) != 0) ? 3'b111 : 3'($urandom()),
					pick_rate(), pick_size(), pick_rate(), pick_size(),
					pick_rate(), pick_size());
			endcase
			// swap idling sides after four phases, then run flat out
			case (phase / 4)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 83;
				end
				1: begin
					send_idle_pct = 83;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (PHASE_PKTS) pending_pkts.push_back(gen_packet());
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[port_classified_token_bucket_policer] OK");
		else
			$display("[port_classified_token_bucket_policer] ERROR");
		$finish;
	end

endmodule
